// ===== hw/rtl/pcxrle_pkg.sv =====
// Shared constants and controller/datapath handshake structs for the PCX RLE decoder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package pcxrle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned PLANE_W = 2;
    localparam int unsigned PCNT_W  = 3;
    localparam int unsigned RUN_W   = 6;
    localparam int unsigned CIDX_W  = 2;

    localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_BYTES_PER_LINE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PLANE_COUNT    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_LINE_COUNT     = 2'd2;

    // Datapath status seen by the controller
    typedef struct packed {
        logic finished;
        logic awaiting;
        logic is_mark;
        logic pend_zero;
        logic pend_one;
        logic remain_one;
        logic done_now;
    } t_status;

    // Controller commands to the datapath
    typedef struct packed {
        logic load_mark;
        logic take_value;
        logic emit;
        logic emit_src_in;
        logic last;
        logic dec_run;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/pcxrle_in_if.sv =====
// Input channel of the PCX RLE decoder: valid/ready plus one coded byte.
// Depends on pcxrle_pkg for field widths.
`default_nettype none

interface pcxrle_in_if;
    logic                             valid;
    logic                             ready;
    logic [pcxrle_pkg::BYTE_W-1:0]    coded_byte;

    modport source (output valid, output coded_byte, input ready);
    modport sink   (input valid, input coded_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcxrle_out_if.sv =====
// Output channel of the PCX RLE decoder: valid/ready plus one tagged pixel byte.
// Depends on pcxrle_pkg for field widths.
`default_nettype none

interface pcxrle_out_if;
    logic                              valid;
    logic                              ready;
    logic [pcxrle_pkg::BYTE_W-1:0]     pixel_byte;
    logic [pcxrle_pkg::PLANE_W-1:0]    plane_index;
    logic [pcxrle_pkg::COUNT_W-1:0]    column_index;
    logic [pcxrle_pkg::COUNT_W-1:0]    row_index;
    logic                              run_last;
    logic                              image_done;

    modport source (output valid, output pixel_byte, output plane_index, output column_index,
                    output row_index, output run_last, output image_done, input ready);
    modport sink   (input valid, input pixel_byte, input plane_index, input column_index,
                    input row_index, input run_last, input image_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcxrle_ctrl.sv =====
// Controller of the PCX RLE decoder: sequences literal, run-mark and run transfers.
// Depends on pcxrle_pkg for the command and status structs.
`default_nettype none

module pcxrle_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  pcxrle_pkg::t_status i_status,
    output pcxrle_pkg::t_cmd    o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;
    logic   in_xfer;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && slot_free;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && !i_status.finished) begin
                    if (i_status.awaiting) begin
                        o_cmd.take_value = 1'b1;
                        if (!i_status.pend_zero) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_src_in = 1'b1;
                            o_cmd.last        = i_status.pend_one || i_status.done_now;
                            if (!(i_status.pend_one || i_status.done_now)) begin
                                n_state = ST_RUN;
                            end
                        end
                    end else if (i_status.is_mark) begin
                        o_cmd.load_mark = 1'b1;
                    end else begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_src_in = 1'b1;
                        o_cmd.last        = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (slot_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.dec_run = 1'b1;
                    o_cmd.last    = i_status.remain_one || i_status.done_now;
                    if (i_status.remain_one || i_status.done_now) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcxrle_dp.sv =====
// Datapath of the PCX RLE decoder: config registers, run state, position counters
// and the output payload register. Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [pcxrle_pkg::CIDX_W-1:0]        i_cfg_idx,
    input  wire  [pcxrle_pkg::COUNT_W-1:0]       i_cfg_data,
    input  wire  [pcxrle_pkg::BYTE_W-1:0]        i_coded_byte,
    input  pcxrle_pkg::t_cmd                     i_cmd,
    output pcxrle_pkg::t_status                  o_status,
    output logic [pcxrle_pkg::BYTE_W-1:0]        o_pixel_byte,
    output logic [pcxrle_pkg::PLANE_W-1:0]       o_plane_index,
    output logic [pcxrle_pkg::COUNT_W-1:0]       o_column_index,
    output logic [pcxrle_pkg::COUNT_W-1:0]       o_row_index,
    output logic                                 o_run_last,
    output logic                                 o_image_done
);

    localparam int unsigned CW = pcxrle_pkg::COUNT_W;

    logic [CW-1:0]                      r_bpl;
    logic [pcxrle_pkg::PCNT_W-1:0]      r_planes;
    logic [CW-1:0]                      r_lines;

    logic                               r_awaiting;
    logic [pcxrle_pkg::RUN_W-1:0]       r_pending;
    logic [pcxrle_pkg::RUN_W-1:0]       r_remain;
    logic [pcxrle_pkg::BYTE_W-1:0]      r_value;
    logic [CW-1:0]                      r_col;
    logic [pcxrle_pkg::PLANE_W-1:0]     r_plane;
    logic [CW-1:0]                      r_row;
    logic                               r_finished;

    logic [pcxrle_pkg::BYTE_W-1:0]      r_pixel;
    logic [pcxrle_pkg::PLANE_W-1:0]     r_plane_out;
    logic [CW-1:0]                      r_col_out;
    logic [CW-1:0]                      r_row_out;
    logic                               r_last_out;
    logic                               r_done_out;

    logic [CW-1:0]                      bpl_lim;
    logic [CW-1:0]                      lines_lim;
    logic [pcxrle_pkg::PCNT_W-1:0]      planes_lim;
    logic                               end_col;
    logic                               end_plane;
    logic                               end_row;
    logic                               done_now;
    logic [pcxrle_pkg::BYTE_W-1:0]      emit_byte;

    // Out-of-range limits: zero acts as one, more than four planes acts as four
    assign bpl_lim   = (r_bpl == '0) ? CW'(1) : r_bpl;
    assign lines_lim = (r_lines == '0) ? CW'(1) : r_lines;
    always_comb begin
        if (r_planes == '0) begin
            planes_lim = 3'd1;
        end else if (r_planes > 3'd4) begin
            planes_lim = 3'd4;
        end else begin
            planes_lim = r_planes;
        end
    end

    assign end_col   = ({1'b0, r_col} + (CW+1)'(1)) >= {1'b0, bpl_lim};
    assign end_plane = ({1'b0, r_plane} + 3'd1) >= planes_lim;
    assign end_row   = ({1'b0, r_row} + (CW+1)'(1)) >= {1'b0, lines_lim};
    assign done_now  = end_col && end_plane && end_row;

    assign emit_byte = i_cmd.emit_src_in ? i_coded_byte : r_value;

    assign o_status.finished   = r_finished;
    assign o_status.awaiting   = r_awaiting;
    assign o_status.is_mark    = i_coded_byte >= pcxrle_pkg::RUN_MARK;
    assign o_status.pend_zero  = (r_pending == '0);
    assign o_status.pend_one   = (r_pending == pcxrle_pkg::RUN_W'(1));
    assign o_status.remain_one = (r_remain == pcxrle_pkg::RUN_W'(1));
    assign o_status.done_now   = done_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpl    <= CW'(1);
            r_planes <= 3'd1;
            r_lines  <= CW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcxrle_pkg::CFG_BYTES_PER_LINE: r_bpl    <= i_cfg_data;
                pcxrle_pkg::CFG_PLANE_COUNT:    r_planes <= i_cfg_data[pcxrle_pkg::PCNT_W-1:0];
                pcxrle_pkg::CFG_LINE_COUNT:     r_lines  <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_pending  <= '0;
            r_remain   <= '0;
            r_col      <= '0;
            r_plane    <= '0;
            r_row      <= '0;
            r_finished <= 1'b0;
        end else begin
            if (i_cmd.load_mark) begin
                r_awaiting <= 1'b1;
                r_pending  <= i_coded_byte[pcxrle_pkg::RUN_W-1:0];
            end
            if (i_cmd.take_value) begin
                r_awaiting <= 1'b0;
                r_pending  <= '0;
                r_remain   <= r_pending - pcxrle_pkg::RUN_W'(1);
            end else if (i_cmd.dec_run) begin
                r_remain <= r_remain - pcxrle_pkg::RUN_W'(1);
            end
            if (i_cmd.emit) begin
                if (end_col) begin
                    r_col <= '0;
                    if (end_plane) begin
                        r_plane <= '0;
                        if (end_row) begin
                            r_row      <= '0;
                            r_finished <= 1'b1;
                        end else begin
                            r_row <= r_row + CW'(1);
                        end
                    end else begin
                        r_plane <= r_plane + pcxrle_pkg::PLANE_W'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Payload registers: value byte for runs and the output slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_value) begin
            r_value <= i_coded_byte;
        end
        if (i_cmd.emit) begin
            r_pixel     <= emit_byte;
            r_plane_out <= r_plane;
            r_col_out   <= r_col;
            r_row_out   <= r_row;
            r_last_out  <= i_cmd.last;
            r_done_out  <= done_now;
        end
    end

    assign o_pixel_byte   = r_pixel;
    assign o_plane_index  = r_plane_out;
    assign o_column_index = r_col_out;
    assign o_row_index    = r_row_out;
    assign o_run_last     = r_last_out;
    assign o_image_done   = r_done_out;

endmodule

`default_nettype wire

// ===== hw/rtl/pcx_rle_scanline_decoder_core.sv =====
// PCX RLE scanline decoder top level. A result is registered and appears in the cycle
// after the transfer that causes it. A literal or run-mark byte is taken whenever the
// output slot is free; a run value byte holds the input off while the controller's run
// state emits the rest of the run, one emission per cycle while the output is ready.
// Reset is synchronous, active low: counters and run state clear, limits return to one.
// Depends on pcxrle_pkg, pcxrle_in_if, pcxrle_out_if, pcxrle_ctrl and pcxrle_dp.
`default_nettype none

module pcx_rle_scanline_decoder_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [pcxrle_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  wire  [pcxrle_pkg::COUNT_W-1:0]   i_cfg_data,
    pcxrle_in_if.sink                        i_in,
    pcxrle_out_if.source                     o_out
);

    pcxrle_pkg::t_cmd    cmd;
    pcxrle_pkg::t_status status;
    logic                in_ready;
    logic                out_valid;

    pcxrle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pcxrle_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_coded_byte   (i_in.coded_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_pixel_byte   (o_out.pixel_byte),
        .o_plane_index  (o_out.plane_index),
        .o_column_index (o_out.column_index),
        .o_row_index    (o_out.row_index),
        .o_run_last     (o_out.run_last),
        .o_image_done   (o_out.image_done)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

`default_nettype wire
